/* hdl/assert_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define AST_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/adrc_rc_pkg.sv */
package adrc_rc_pkg;

  // Fixed-point format and derived constants.
  localparam int FRAC_BITS = 16;
  localparam int STEP_SIZE_Q16 = 328;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] DEAD_Q = 32'((2 ** FRAC_BITS + 500) / 1000);
  localparam logic signed [31:0] HEIGHT_LIMIT = 32'sd21 <<< FRAC_BITS;

  // Widths of the working values.
  localparam int SW = 68;                  // saturation input width
  localparam int PW = 66;                  // multiplier product width
  localparam int QW = 63 - FRAC_BITS;      // tracking ratio width
  localparam int DVW = 36 + FRAC_BITS;     // divider dividend width
  localparam int DNW = 48;                 // divider divisor width
  localparam int SQW = 63;                 // square root working width
  localparam logic [QW-1:0] RATIO_CAP = QW'((64'd1 << (62 - FRAC_BITS)) - (64'd1 << FRAC_BITS));

  // Register file indexes.
  typedef enum logic [2:0] {
    REG_TRACK_SPEED   = 3'd0,
    REG_FILTER_STEP   = 3'd1,
    REG_OBS_GAIN_ONE  = 3'd2,
    REG_OBS_GAIN_TWO  = 3'd3,
    REG_OBS_GAIN_THREE = 3'd4,
    REG_INPUT_GAIN    = 3'd5,
    REG_PROP_GAIN     = 3'd6,
    REG_DERIV_GAIN    = 3'd7
  } cfg_reg_t;

  // Register reset values.
  localparam logic [30:0] RST_TRACK_SPEED = 31'd1310720000;
  localparam logic [15:0] RST_FILTER_STEP = 16'd524;
  localparam logic [30:0] RST_OBS_GAIN_ONE = 31'd5898240;
  localparam logic [30:0] RST_OBS_GAIN_TWO = 31'd78643200;
  localparam logic [30:0] RST_OBS_GAIN_THREE = 31'd45875200;
  localparam logic [30:0] RST_INPUT_GAIN = 31'd655360;
  localparam logic [30:0] RST_PROP_GAIN = 31'd85197;
  localparam logic [30:0] RST_DERIV_GAIN = 31'd1311;

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Fixed-point product: floor shift of the raw product, then clamp.
  function automatic logic signed [31:0] mulq(input logic signed [PW-1:0] p);
    return sat32(SW'(p >>> FRAC_BITS));
  endfunction

  // Magnitude of a 32-bit signed value.
  function automatic logic [32:0] abs33(input logic signed [31:0] x);
    logic signed [32:0] e;
    e = 33'(x);
    return x[31] ? 33'(-e) : 33'(e);
  endfunction

  // Signed, clamped quotient from a magnitude and a sign.
  function automatic logic signed [31:0] divres(input logic [DVW-1:0] mag, input logic neg);
    if (neg) begin
      if (mag > DVW'(64'd2147483648)) begin
        return 32'sh80000000;
      end
      return 32'(32'd0 - mag[31:0]);
    end
    if (mag > DVW'(64'd2147483647)) begin
      return 32'sh7fffffff;
    end
    return $signed(mag[31:0]);
  endfunction

  // Sign with dead band, scaled to one.
  function automatic logic signed [31:0] sgn_one(input logic signed [31:0] x);
    if (x > DEAD_Q) begin
      return ONE_Q;
    end else if (x < -DEAD_Q) begin
      return -ONE_Q;
    end
    return 32'sd0;
  endfunction

  // True when x lies inside the linear band of the saturation function.
  function automatic logic in_band(input logic signed [31:0] x, input logic signed [31:0] sig);
    logic signed [33:0] xe;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    xe = 34'(x);
    lo = 34'(DEAD_Q) - 34'(sig);
    hi = 34'(sig) - 34'(DEAD_Q);
    return (xe > lo) && (xe < hi);
  endfunction

  // Far-branch offset sign(y) * (2 - k) / 2, clamped.
  function automatic logic signed [31:0] far_a(input logic signed [31:0] y, input logic [16:0] k);
    logic signed [33:0] base;
    logic signed [31:0] s;
    base = (34'sd2 - $signed({17'b0, k})) <<< (FRAC_BITS - 1);
    s = sgn_one(y);
    if (s > 32'sd0) begin
      return sat32(SW'(base));
    end else if (s < 32'sd0) begin
      return sat32(SW'(-base));
    end
    return 32'sd0;
  endfunction

endpackage

/* hdl/adrc_rate_controller_top.sv */
// ADRC rate controller: one control step per input item.
// Input channel (in_valid / in_stall): setpoint, measured rate and height, signed Q16.16.
// Result channel (out_valid / out_stall): drive, tracked value and rate, and the three
// observer states, all signed Q16.16 and saturated. Every input item gives one result item.
// Configuration: write cfg_data to register cfg_index while cfg_we is high; writes take
// effect at once. The user must make writes only while the block is idle; the block
// itself does not enforce this. All arithmetic runs on one shared 33x33 multiplier, one
// restoring divider (one quotient bit per cycle) and one square root unit (one root bit
// per cycle), stepped by a sequencer. The time an item takes from accept to result is
// set by the number of divisions in its path (none to four) and the branch taken; the
// next item can be accepted in the cycle after the result is written.
// in_stall is high from the accept until the result is written to the output register.
// The result register holds while out_stall is high; a finished step waits for it to
// drain, and a new item may be accepted while a result still waits.
// Synchronous reset (rst_n low) restores register defaults, clears controller state and
// drops out_valid.
module adrc_rate_controller_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_setpoint,
  input  logic signed [31:0] in_measured,
  input  logic signed [31:0] in_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive,
  output logic signed [31:0] out_tracked_value,
  output logic signed [31:0] out_tracked_rate,
  output logic signed [31:0] out_est_value,
  output logic signed [31:0] out_est_rate,
  output logic signed [31:0] out_est_disturbance,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE, S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_QDONE, S_KSQ, S_KCALC,
    S_N0, S_NT, S_N1, S_NS, S_G0, S_G1, S_G2, S_GQ, S_G3, S_FM, S_FR,
    S_U0, S_U1, S_U2, S_O0, S_O1, S_O2, S_O3, S_O4, S_O5, S_O6, S_O7,
    S_D0, S_D1, S_D2, S_DD, S_D3, S_DONE, S_DIV, S_SQRT
  } state_t;

  // Configuration registers.
  logic [30:0] track_speed_r;
  logic [15:0] filter_step_r;
  logic [30:0] gain_one_r;
  logic [30:0] gain_two_r;
  logic [30:0] gain_three_r;
  logic [30:0] input_gain_r;
  logic [30:0] prop_gain_r;
  logic [30:0] deriv_gain_r;

  // Controller state.
  logic signed [31:0] track_pos_r;
  logic signed [31:0] track_vel_r;
  logic signed [31:0] obs_pos_r;
  logic signed [31:0] obs_vel_r;
  logic signed [31:0] obs_dist_r;
  logic signed [31:0] prev_drive_r;

  // Sequencer and working registers.
  state_t             state_r;
  state_t             ret_r;
  logic signed [31:0] sp_r;
  logic signed [31:0] hgt_r;
  logic signed [31:0] v1_r;
  logic signed [31:0] e_r;
  logic signed [31:0] hv2_r;
  logic signed [31:0] y_r;
  logic signed [31:0] hh_r;
  logic signed [31:0] d_r;
  logic signed [31:0] sig_r;
  logic [adrc_rc_pkg::QW-1:0] q_r;
  logic [16:0]        k_r;
  logic               far_r;
  logic signed [31:0] t_r;
  logic signed [31:0] s_r;
  logic signed [31:0] num_r;
  logic signed [31:0] quo_r;
  logic signed [31:0] fv_r;
  logic signed [31:0] t1_r;
  logic signed [31:0] t2_r;
  logic signed [32:0] t3_r;
  logic signed [31:0] nz1_r;
  logic signed [31:0] nz2_r;
  logic signed [31:0] pterm_r;
  logic signed [31:0] u0_r;
  logic signed [31:0] dist_r;
  logic signed [adrc_rc_pkg::PW-1:0] prod_r;

  // Shared divider and square root unit.
  logic [adrc_rc_pkg::DVW-1:0] dv_q_r;
  logic [adrc_rc_pkg::DNW-1:0] dv_rem_r;
  logic [adrc_rc_pkg::DNW-1:0] dv_den_r;
  logic               dv_neg_r;
  logic [5:0]         cnt_r;
  logic [adrc_rc_pkg::SQW-1:0] sq_v_r;
  logic [adrc_rc_pkg::SQW-1:0] sq_res_r;
  logic [adrc_rc_pkg::SQW-1:0] sq_bit_r;

  // Output register.
  logic               out_valid_r;
  logic signed [31:0] out_drive_r;
  logic signed [31:0] out_tv_r;
  logic signed [31:0] out_tr_r;
  logic signed [31:0] out_ev_r;
  logic signed [31:0] out_er_r;
  logic signed [31:0] out_ed_r;

  // Combinational helpers.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [31:0] mq;
  logic [32:0]        ya;
  logic [adrc_rc_pkg::DNW:0]   dv_sh;
  logic               dv_ge;
  logic [adrc_rc_pkg::DNW-1:0] dv_rem_nxt;
  logic [adrc_rc_pkg::SQW:0]   sq_trial;
  logic [32:0]        kd;
  logic [16:0]        kfix;
  logic [16:0]        k_nxt;
  logic signed [31:0] x_val;
  logic signed [31:0] w_val;
  logic signed [31:0] u_val;
  logic signed [31:0] fv_q;

  assign mq = adrc_rc_pkg::mulq(prod_r);
  assign ya = adrc_rc_pkg::abs33(y_r);

  // Divider step: shift in one dividend bit and try to subtract.
  assign dv_sh = {dv_rem_r, dv_q_r[adrc_rc_pkg::DVW-1]};
  assign dv_ge = dv_sh >= {1'b0, dv_den_r};
  assign dv_rem_nxt = dv_ge ? adrc_rc_pkg::DNW'(dv_sh - {1'b0, dv_den_r})
                            : adrc_rc_pkg::DNW'(dv_sh);

  // Square root step trial value.
  assign sq_trial = {1'b0, sq_res_r} + {1'b0, sq_bit_r};

  // Ceiling k from the root.
  assign kd = (33'(adrc_rc_pkg::ONE_Q) + 33'(sq_res_r)) >> 1;
  assign kfix = kd[32:adrc_rc_pkg::FRAC_BITS];
  assign k_nxt = (kfix > 17'd65535) ? 17'd65535 :
                 kfix + ((33'(kd[adrc_rc_pkg::FRAC_BITS-1:0]) > 33'(adrc_rc_pkg::DEAD_Q))
                         ? 17'd1 : 17'd0);

  assign x_val = adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(track_vel_r) + adrc_rc_pkg::SW'(t_r));
  assign w_val = adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(adrc_rc_pkg::far_a(y_r, k_r))
                                    - adrc_rc_pkg::SW'(quo_r));
  assign u_val = adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(u0_r) - adrc_rc_pkg::SW'(dist_r));
  assign fv_q = far_r ? mq : adrc_rc_pkg::sat32(-adrc_rc_pkg::SW'(mq));

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_F0: begin
        mul_a = $signed({17'b0, filter_step_r});
        mul_b = 33'(track_vel_r);
      end
      S_F1: begin
        mul_a = $signed({17'b0, filter_step_r});
        mul_b = $signed({17'b0, filter_step_r});
      end
      S_F3: begin
        mul_a = 33'(hh_r);
        mul_b = $signed({2'b0, track_speed_r});
      end
      S_F4: begin
        mul_a = $signed({17'b0, filter_step_r});
        mul_b = $signed({2'b0, track_speed_r});
      end
      S_G0: begin
        mul_a = $signed({16'b0, k_r});
        mul_b = 33'(hv2_r);
      end
      S_G1: begin
        mul_a = $signed({16'b0, 17'(k_r - 17'd1)});
        mul_b = 33'(d_r);
      end
      S_FM: begin
        mul_a = $signed({2'b0, track_speed_r});
        mul_b = 33'(s_r);
      end
      S_U0: begin
        mul_a = 33'(adrc_rc_pkg::STEP_SIZE_Q16);
        mul_b = 33'(track_vel_r);
      end
      S_U1: begin
        mul_a = 33'(adrc_rc_pkg::STEP_SIZE_Q16);
        mul_b = 33'(fv_r);
      end
      S_O0: begin
        mul_a = $signed({2'b0, gain_one_r});
        mul_b = 33'(e_r);
      end
      S_O1: begin
        mul_a = $signed({2'b0, gain_two_r});
        mul_b = 33'(e_r);
      end
      S_O2: begin
        mul_a = $signed({2'b0, input_gain_r});
        mul_b = 33'(prev_drive_r);
      end
      S_O3: begin
        mul_a = $signed({2'b0, gain_three_r});
        mul_b = 33'(e_r);
      end
      S_O4: begin
        mul_a = 33'(adrc_rc_pkg::STEP_SIZE_Q16);
        mul_b = 33'(t1_r);
      end
      S_O5: begin
        mul_a = 33'(adrc_rc_pkg::STEP_SIZE_Q16);
        mul_b = 33'(t2_r);
      end
      S_O6: begin
        mul_a = 33'(adrc_rc_pkg::STEP_SIZE_Q16);
        mul_b = t3_r;
      end
      S_D0: begin
        mul_a = $signed({2'b0, prop_gain_r});
        mul_b = 33'(adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(sp_r) - adrc_rc_pkg::SW'(obs_pos_r)));
      end
      S_D1: begin
        mul_a = $signed({2'b0, deriv_gain_r});
        mul_b = 33'(adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(track_vel_r)
                                       - adrc_rc_pkg::SW'(obs_vel_r)));
      end
      default: begin
      end
    endcase
  end

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_speed_r <= adrc_rc_pkg::RST_TRACK_SPEED;
      filter_step_r <= adrc_rc_pkg::RST_FILTER_STEP;
      gain_one_r    <= adrc_rc_pkg::RST_OBS_GAIN_ONE;
      gain_two_r    <= adrc_rc_pkg::RST_OBS_GAIN_TWO;
      gain_three_r  <= adrc_rc_pkg::RST_OBS_GAIN_THREE;
      input_gain_r  <= adrc_rc_pkg::RST_INPUT_GAIN;
      prop_gain_r   <= adrc_rc_pkg::RST_PROP_GAIN;
      deriv_gain_r  <= adrc_rc_pkg::RST_DERIV_GAIN;
    end else if (cfg_we) begin
      unique case (adrc_rc_pkg::cfg_reg_t'(cfg_index))
        adrc_rc_pkg::REG_TRACK_SPEED:    track_speed_r <= cfg_data;
        adrc_rc_pkg::REG_FILTER_STEP:    filter_step_r <= cfg_data[15:0];
        adrc_rc_pkg::REG_OBS_GAIN_ONE:   gain_one_r <= cfg_data;
        adrc_rc_pkg::REG_OBS_GAIN_TWO:   gain_two_r <= cfg_data;
        adrc_rc_pkg::REG_OBS_GAIN_THREE: gain_three_r <= cfg_data;
        adrc_rc_pkg::REG_INPUT_GAIN:     input_gain_r <= cfg_data;
        adrc_rc_pkg::REG_PROP_GAIN:      prop_gain_r <= cfg_data;
        adrc_rc_pkg::REG_DERIV_GAIN:     deriv_gain_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer, shared units and result register.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      out_valid_r  <= 1'b0;
      track_pos_r  <= '0;
      track_vel_r  <= '0;
      obs_pos_r    <= '0;
      obs_vel_r    <= '0;
      obs_dist_r   <= '0;
      prev_drive_r <= '0;
    end else begin
      // A taken result frees the register unless a new one is loaded at this edge.
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sp_r    <= in_setpoint;
            hgt_r   <= in_height;
            v1_r    <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(track_pos_r)
                                          - adrc_rc_pkg::SW'(in_setpoint));
            e_r     <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(obs_pos_r)
                                          - adrc_rc_pkg::SW'(in_measured));
            state_r <= S_F0;
          end
        end
        S_F0: state_r <= S_F1;
        S_F1: begin
          hv2_r   <= mq;
          state_r <= S_F2;
        end
        S_F2: begin
          y_r     <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(v1_r) + adrc_rc_pkg::SW'(hv2_r));
          hh_r    <= mq;
          state_r <= S_F3;
        end
        S_F3: state_r <= S_F4;
        S_F4: begin
          d_r     <= mq;
          state_r <= S_F5;
        end
        // Tracking ratio 8|y|/d, or the cap when d is zero.
        S_F5: begin
          sig_r <= mq;
          if (d_r == 32'sd0) begin
            q_r     <= adrc_rc_pkg::RATIO_CAP;
            state_r <= S_KSQ;
          end else begin
            dv_q_r   <= adrc_rc_pkg::DVW'(ya) << (adrc_rc_pkg::FRAC_BITS + 3);
            dv_rem_r <= '0;
            dv_den_r <= adrc_rc_pkg::DNW'(d_r);
            dv_neg_r <= 1'b0;
            cnt_r    <= 6'(adrc_rc_pkg::DVW - 1);
            ret_r    <= S_QDONE;
            state_r  <= S_DIV;
          end
        end
        S_QDONE: begin
          q_r     <= (dv_q_r > adrc_rc_pkg::DVW'(adrc_rc_pkg::RATIO_CAP))
                     ? adrc_rc_pkg::RATIO_CAP : adrc_rc_pkg::QW'(dv_q_r);
          state_r <= S_KSQ;
        end
        S_KSQ: begin
          sq_v_r   <= adrc_rc_pkg::SQW'(adrc_rc_pkg::QW'(adrc_rc_pkg::ONE_Q) + q_r)
                      << adrc_rc_pkg::FRAC_BITS;
          sq_res_r <= '0;
          sq_bit_r <= adrc_rc_pkg::SQW'(1) << (adrc_rc_pkg::SQW - 1);
          cnt_r    <= 6'd31;
          ret_r    <= S_KCALC;
          state_r  <= S_SQRT;
        end
        // Ceiling k and the choice between the near and the far branch.
        S_KCALC: begin
          k_r     <= k_nxt;
          far_r   <= ya > 33'(d_r);
          state_r <= (ya > 33'(d_r)) ? S_G0 : S_N0;
        end
        S_N0: begin
          if (filter_step_r == 16'd0) begin
            t_r     <= '0;
            state_r <= S_N1;
          end else begin
            dv_q_r   <= adrc_rc_pkg::DVW'(adrc_rc_pkg::abs33(y_r)) << adrc_rc_pkg::FRAC_BITS;
            dv_rem_r <= '0;
            dv_den_r <= adrc_rc_pkg::DNW'(filter_step_r);
            dv_neg_r <= y_r[31];
            cnt_r    <= 6'(adrc_rc_pkg::DVW - 1);
            ret_r    <= S_NT;
            state_r  <= S_DIV;
          end
        end
        S_NT: begin
          t_r     <= adrc_rc_pkg::divres(dv_q_r, dv_neg_r);
          state_r <= S_N1;
        end
        // Near branch saturation function with width sigma.
        S_N1: begin
          if (adrc_rc_pkg::in_band(x_val, sig_r)) begin
            dv_q_r   <= adrc_rc_pkg::DVW'(adrc_rc_pkg::abs33(x_val)) << adrc_rc_pkg::FRAC_BITS;
            dv_rem_r <= '0;
            dv_den_r <= adrc_rc_pkg::DNW'(sig_r);
            dv_neg_r <= x_val[31];
            cnt_r    <= 6'(adrc_rc_pkg::DVW - 1);
            ret_r    <= S_NS;
            state_r  <= S_DIV;
          end else begin
            s_r     <= adrc_rc_pkg::sgn_one(x_val);
            state_r <= S_FM;
          end
        end
        S_NS: begin
          s_r     <= adrc_rc_pkg::divres(dv_q_r, dv_neg_r);
          state_r <= S_FM;
        end
        S_G0: state_r <= S_G1;
        S_G1: begin
          num_r   <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(v1_r) + adrc_rc_pkg::SW'(prod_r));
          state_r <= S_G2;
        end
        // Far branch quotient num / ((k-1)*d).
        S_G2: begin
          if (prod_r == '0) begin
            quo_r   <= (num_r > 32'sd0) ? 32'sh7fffffff :
                       ((num_r < 32'sd0) ? 32'sh80000000 : 32'sd0);
            state_r <= S_G3;
          end else begin
            dv_q_r   <= adrc_rc_pkg::DVW'(adrc_rc_pkg::abs33(num_r)) << adrc_rc_pkg::FRAC_BITS;
            dv_rem_r <= '0;
            dv_den_r <= adrc_rc_pkg::DNW'(prod_r);
            dv_neg_r <= num_r[31];
            cnt_r    <= 6'(adrc_rc_pkg::DVW - 1);
            ret_r    <= S_GQ;
            state_r  <= S_DIV;
          end
        end
        S_GQ: begin
          quo_r   <= adrc_rc_pkg::divres(dv_q_r, dv_neg_r);
          state_r <= S_G3;
        end
        // Unit-width saturation needs no division.
        S_G3: begin
          s_r     <= adrc_rc_pkg::in_band(w_val, adrc_rc_pkg::ONE_Q) ? w_val
                     : adrc_rc_pkg::sgn_one(w_val);
          state_r <= S_FM;
        end
        S_FM: state_r <= S_FR;
        S_FR: begin
          fv_r    <= fv_q;
          state_r <= S_U0;
        end
        // Tracking differentiator state update.
        S_U0: state_r <= S_U1;
        S_U1: begin
          track_pos_r <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(track_pos_r)
                                            + adrc_rc_pkg::SW'(mq));
          state_r     <= S_U2;
        end
        S_U2: begin
          track_vel_r <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(track_vel_r)
                                            + adrc_rc_pkg::SW'(mq));
          state_r     <= S_O0;
        end
        // Extended state observer.
        S_O0: state_r <= S_O1;
        S_O1: begin
          t1_r    <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(obs_vel_r) - adrc_rc_pkg::SW'(mq));
          state_r <= S_O2;
        end
        S_O2: begin
          t2_r    <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(obs_dist_r) - adrc_rc_pkg::SW'(mq));
          state_r <= S_O3;
        end
        S_O3: begin
          t2_r    <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(t2_r) + adrc_rc_pkg::SW'(mq));
          state_r <= S_O4;
        end
        S_O4: begin
          t3_r    <= -(33'(mq));
          state_r <= S_O5;
        end
        S_O5: begin
          nz1_r   <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(obs_pos_r) + adrc_rc_pkg::SW'(mq));
          state_r <= S_O6;
        end
        S_O6: begin
          nz2_r   <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(obs_vel_r) + adrc_rc_pkg::SW'(mq));
          state_r <= S_O7;
        end
        // Commit the observer; the disturbance is cleared close to the ground.
        S_O7: begin
          obs_pos_r  <= nz1_r;
          obs_vel_r  <= nz2_r;
          obs_dist_r <= (hgt_r < adrc_rc_pkg::HEIGHT_LIMIT) ? 32'sd0
                        : adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(obs_dist_r)
                                             + adrc_rc_pkg::SW'(mq));
          state_r    <= S_D0;
        end
        // Drive law.
        S_D0: state_r <= S_D1;
        S_D1: begin
          pterm_r <= mq;
          state_r <= S_D2;
        end
        S_D2: begin
          u0_r <= adrc_rc_pkg::sat32(adrc_rc_pkg::SW'(pterm_r) + adrc_rc_pkg::SW'(mq));
          if (input_gain_r == 31'd0) begin
            dist_r  <= '0;
            state_r <= S_D3;
          end else begin
            dv_q_r   <= adrc_rc_pkg::DVW'(adrc_rc_pkg::abs33(obs_dist_r))
                        << adrc_rc_pkg::FRAC_BITS;
            dv_rem_r <= '0;
            dv_den_r <= adrc_rc_pkg::DNW'(input_gain_r);
            dv_neg_r <= obs_dist_r[31];
            cnt_r    <= 6'(adrc_rc_pkg::DVW - 1);
            ret_r    <= S_DD;
            state_r  <= S_DIV;
          end
        end
        S_DD: begin
          dist_r  <= adrc_rc_pkg::divres(dv_q_r, dv_neg_r);
          state_r <= S_D3;
        end
        S_D3: begin
          prev_drive_r <= u_val;
          state_r      <= S_DONE;
        end
        // Hand the result over once the output register is free.
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_drive_r <= prev_drive_r;
            out_tv_r    <= track_pos_r;
            out_tr_r    <= track_vel_r;
            out_ev_r    <= obs_pos_r;
            out_er_r    <= obs_vel_r;
            out_ed_r    <= obs_dist_r;
            state_r     <= S_IDLE;
          end
        end
        // One quotient bit per cycle.
        S_DIV: begin
          dv_rem_r <= dv_rem_nxt;
          dv_q_r   <= {dv_q_r[adrc_rc_pkg::DVW-2:0], dv_ge};
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_r <= ret_r;
          end
        end
        // One root bit per cycle.
        S_SQRT: begin
          if ({1'b0, sq_v_r} >= sq_trial) begin
            sq_v_r   <= adrc_rc_pkg::SQW'({1'b0, sq_v_r} - sq_trial);
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_r <= ret_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_drive           = out_drive_r;
  assign out_tracked_value   = out_tv_r;
  assign out_tracked_rate    = out_tr_r;
  assign out_est_value       = out_ev_r;
  assign out_est_rate        = out_er_r;
  assign out_est_disturbance = out_ed_r;

endmodule

/* hdl/adrc_rc_checker.sv */
`include "assert_macros.svh"

module adrc_rc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // A held result stays until it is taken.
  `AST_CLKD(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  // An accepted item keeps the block busy in the following cycle.
  `AST_CLKD(a_busy_after_acc, in_acc |=> in_stall, "block free right after an accept")
  // No result can appear in the cycle after an accept.
  `AST_CLKD(a_no_instant, in_acc |=> !$rose(out_valid), "result too early after accept")
  // A new result means the block has returned to idle.
  `AST_CLKD(a_free_on_result, $rose(out_valid) |-> !in_stall, "busy when result appears")
  // Reset clears the result channel.
  `AST_CLK(a_reset_clear, !rst_n |=> !out_valid, "out_valid high after reset")

endmodule

bind adrc_rate_controller_top adrc_rc_checker u_adrc_rc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
